/* rtl/core/koc_pkg.sv */
package koc_pkg;

  typedef enum logic [1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_TEXT = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_LONG     = 2'd2,
    ST_UNFILLED = 2'd3
  } status_e;

  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 32;

endpackage

/* rtl/core/koc_ram.sv */
module koc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/keyword_occurrence_counter.sv */
// A character that does not end a word gives no word.
// An unfilled read or a refused word gives its word in the cycle after it is taken; a read passes S_READ first.
// A keyword end copies one character per cycle into the keyword table, then gives its word.
// A text word end walks the table entry by entry, one character compare per cycle; the
// input stalls meanwhile and while a word waits.
// Reset clears the fill count and the word being collected; the memories are not cleared.
module keyword_occurrence_counter #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned WORD_CHARS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  char_code_i,
  input  logic        word_end_i,
  input  logic [9:0]  entry_index_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic        matched_o,
  output logic [9:0]  found_index_o,
  output logic [31:0] occurrences_o
);

  localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
  localparam int unsigned LW = $clog2(WORD_CHARS + 1);
  localparam int unsigned UW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KD = MAX_ENTRIES * WORD_CHARS;
  localparam int unsigned KW = $clog2(KD) > 0 ? $clog2(KD) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RLEN  = 7'b0000010,
    S_CHAR  = 7'b0000100,
    S_CMP   = 7'b0001000,
    S_HIT   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [UW-1:0] used_q, used_d;
  logic [LW-1:0] wlen_q, wlen_d;
  logic          wovf_q, wovf_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [LW-1:0] ci_q, ci_d;
  logic          ok_q, ok_d;
  logic          ovalid_q, ovalid_d;
  logic [1:0]    ostat_q, ostat_d;
  logic          omatch_q, omatch_d;
  logic [9:0]    oidx_q, oidx_d;
  logic [31:0]   oocc_q, oocc_d;

  logic          wb_we;
  logic [CW-1:0] wb_wa, wb_ra;
  logic [7:0]    wb_rd;
  logic          kc_we;
  logic [KW-1:0] kc_wa, kc_ra;
  logic [7:0]    kc_rd;
  logic          kl_we;
  logic [EW-1:0] kl_wa, kl_ra;
  logic [LW-1:0] kl_rd;
  logic          oc_we;
  logic [EW-1:0] oc_wa, oc_ra;
  logic [31:0]   oc_wd, oc_rd;

  logic          acc;
  logic          is_char;
  logic          ovf_now;
  logic [LW-1:0] len_now;

  koc_ram #(.Width(8), .Depth(WORD_CHARS)) u_wbuf (
    .clk_i, .we_i(wb_we), .waddr_i(wb_wa), .wdata_i(char_code_i),
    .raddr_i(wb_ra), .rdata_o(wb_rd)
  );
  koc_ram #(.Width(8), .Depth(KD)) u_kchars (
    .clk_i, .we_i(kc_we), .waddr_i(kc_wa), .wdata_i(wb_rd),
    .raddr_i(kc_ra), .rdata_o(kc_rd)
  );
  koc_ram #(.Width(LW), .Depth(MAX_ENTRIES)) u_klen (
    .clk_i, .we_i(kl_we), .waddr_i(kl_wa), .wdata_i(wlen_q),
    .raddr_i(kl_ra), .rdata_o(kl_rd)
  );
  koc_ram #(.Width(32), .Depth(MAX_ENTRIES)) u_count (
    .clk_i, .we_i(oc_we), .waddr_i(oc_wa), .wdata_i(oc_wd),
    .raddr_i(oc_ra), .rdata_o(oc_rd)
  );

  assign stall_o       = (state_q != S_IDLE) || (ovalid_q && stall_i);
  assign acc           = valid_i && !stall_o;
  assign is_char       = (func_i == koc_pkg::FUNC_KEY) || (func_i == koc_pkg::FUNC_TEXT);
  assign valid_o       = ovalid_q;
  assign status_o      = ostat_q;
  assign matched_o     = omatch_q;
  assign found_index_o = oidx_q;
  assign occurrences_o = oocc_q;

  assign ovf_now = wovf_q || (wlen_q == LW'(WORD_CHARS));
  assign len_now = (wlen_q == LW'(WORD_CHARS)) ? wlen_q : wlen_q + LW'(1);

  // The keyword copy and the text compare both walk one character per cycle.
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    wlen_d   = wlen_q;
    wovf_d   = wovf_q;
    ent_d    = ent_q;
    ci_d     = ci_q;
    ok_d     = ok_q;
    ovalid_d = ovalid_q && stall_i;
    ostat_d  = ostat_q;
    omatch_d = omatch_q;
    oidx_d   = oidx_q;
    oocc_d   = oocc_q;
    wb_we    = 1'b0;
    wb_wa    = CW'(wlen_q);
    wb_ra    = CW'(ci_q);
    kc_we    = 1'b0;
    kc_wa    = KW'(ent_q) * KW'(WORD_CHARS) + KW'(ci_q - LW'(1));
    kc_ra    = KW'(ent_q) * KW'(WORD_CHARS) + KW'(ci_q);
    kl_we    = 1'b0;
    kl_wa    = ent_q;
    kl_ra    = ent_q;
    oc_we    = 1'b0;
    oc_wa    = ent_q;
    oc_wd    = '0;
    oc_ra    = ent_q;
    case (state_q)
      S_IDLE: begin
        if (acc && func_i == koc_pkg::FUNC_READ) begin
          if (UW'(entry_index_i) < used_q && 32'(entry_index_i) < MAX_ENTRIES) begin
            ent_d   = EW'(entry_index_i);
            oc_ra   = EW'(entry_index_i);
            state_d = S_READ;
          end else begin
            ostat_d  = koc_pkg::ST_UNFILLED;
            omatch_d = 1'b0;
            oidx_d   = '0;
            oocc_d   = '0;
            ovalid_d = 1'b1;
          end
        end else if (acc && is_char) begin
          wb_we  = !ovf_now;
          wlen_d = len_now;
          wovf_d = ovf_now;
          if (word_end_i) begin
            ostat_d  = koc_pkg::ST_OK;
            omatch_d = 1'b0;
            oidx_d   = '0;
            oocc_d   = '0;
            ci_d     = '0;
            ent_d    = '0;
            if (func_i == koc_pkg::FUNC_KEY) begin
              if (used_q >= UW'(MAX_ENTRIES)) begin
                ostat_d = koc_pkg::ST_FULL;
                ovalid_d = 1'b1;
              end else if (ovf_now) begin
                ostat_d = koc_pkg::ST_LONG;
                ovalid_d = 1'b1;
              end else begin
                ent_d   = EW'(used_q);
                state_d = S_CHAR;
              end
            end else begin
              if (ovf_now) begin
                ostat_d = koc_pkg::ST_LONG;
                ovalid_d = 1'b1;
              end else if (used_q == '0) begin
                ovalid_d = 1'b1;
              end else begin
                state_d = S_RLEN;
              end
            end
            if (ovalid_d) begin
              wlen_d = '0;
              wovf_d = 1'b0;
            end
          end
        end
      end
      S_CHAR: begin
        if (ci_q != '0) begin
          kc_we = 1'b1;
        end
        if (ci_q >= wlen_q) begin
          kl_we    = 1'b1;
          oc_we    = 1'b1;
          used_d   = used_q + UW'(1);
          oidx_d   = 10'(ent_q);
          ovalid_d = 1'b1;
          wlen_d   = '0;
          wovf_d   = 1'b0;
          state_d  = S_IDLE;
        end else begin
          ci_d = ci_q + LW'(1);
        end
      end
      S_RLEN: begin
        ci_d    = '0;
        ok_d    = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (ci_q == '0) begin
          ok_d = (kl_rd == wlen_q);
        end else begin
          ok_d = ok_q && (kc_rd == wb_rd);
        end
        if (ci_q != '0 && !(ok_q && kc_rd == wb_rd)) begin
          ci_d = wlen_q + LW'(1);
          ok_d = 1'b0;
        end else if (ci_q == '0 && kl_rd != wlen_q) begin
          ci_d = wlen_q + LW'(1);
          ok_d = 1'b0;
        end
        if (ci_d == wlen_q + LW'(1)) begin
          if (ok_d && ci_q == wlen_q) begin
            state_d = S_HIT;
          end else if (!ok_d) begin
            if (UW'(ent_q) + UW'(1) >= used_q) begin
              ovalid_d = 1'b1;
              wlen_d   = '0;
              wovf_d   = 1'b0;
              state_d  = S_IDLE;
            end else begin
              ent_d   = ent_q + EW'(1);
              state_d = S_RLEN;
            end
          end
        end
        if (ok_d && ci_q == wlen_q) begin
          state_d = S_HIT;
        end else if (ok_d) begin
          ci_d  = ci_q + LW'(1);
          wb_ra = CW'(ci_q);
          kc_ra = KW'(ent_q) * KW'(WORD_CHARS) + KW'(ci_q);
        end
      end
      S_HIT: begin
        oc_we    = 1'b1;
        oc_wd    = (oc_rd == '1) ? oc_rd : oc_rd + 32'd1;
        omatch_d = 1'b1;
        oidx_d   = 10'(ent_q);
        oocc_d   = oc_wd;
        ostat_d  = koc_pkg::ST_OK;
        ovalid_d = 1'b1;
        wlen_d   = '0;
        wovf_d   = 1'b0;
        state_d  = S_IDLE;
      end
      S_READ: begin
        ostat_d  = koc_pkg::ST_OK;
        omatch_d = 1'b0;
        oidx_d   = 10'(ent_q);
        oocc_d   = oc_rd;
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      wlen_q   <= '0;
      wovf_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      wlen_q   <= wlen_d;
      wovf_q   <= wovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    ci_q     <= ci_d;
    ok_q     <= ok_d;
    ostat_q  <= ostat_d;
    omatch_q <= omatch_d;
    oidx_q   <= oidx_d;
    oocc_q   <= oocc_d;
  end

endmodule

/* test/keyword_occurrence_counter_tb.sv */
module keyword_occurrence_counter_tb;

  typedef struct {
    koc_pkg::status_e status;
    logic             matched;
    logic [9:0]       index;
    logic [31:0]      count;
  } tally_t;

  typedef struct {
    koc_pkg::func_e func;
    logic [7:0]     code;
    logic           last;
    logic [9:0]     index;
    bit             typed;
    tally_t         want;
  } row_t;

  localparam int unsigned Entries  = 1024;
  localparam int unsigned Chars    = 32;
  localparam int unsigned Watchdog = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  func_i = koc_pkg::FUNC_NOP;
  logic [7:0]  char_code_i = '0;
  logic        word_end_i = 1'b0;
  logic [9:0]  entry_index_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        matched_o;
  logic [9:0]  found_index_o;
  logic [31:0] occurrences_o;

  logic [7:0]  kw_text [Entries][Chars];
  logic [5:0]  kw_len [Entries];
  logic [31:0] kw_hits [Entries];
  int unsigned kw_used;
  logic [7:0]  cur_word [Chars];
  int unsigned cur_len;
  bit          cur_over;

  tally_t      pending_tallies [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned cycle_no;
  int unsigned items_sent;
  bit          quiet_send;
  bit          timed_out;
  logic [7:0]  pool [4] = '{8'h00, 8'h41, 8'h42, 8'hFF};

  keyword_occurrence_counter DUT (.*);

  always #10 clk_i = ~clk_i;

  function automatic bit count_step(input koc_pkg::func_e f, input logic [7:0] c,
                                    input logic e, input logic [9:0] x, output tally_t t);
    bit hit;
    t = '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0};
    if (f == koc_pkg::FUNC_NOP) return 0;
    if (f == koc_pkg::FUNC_READ) begin
      if (x < kw_used) t = '{koc_pkg::ST_OK, 1'b0, x, kw_hits[x]};
      else t.status = koc_pkg::ST_UNFILLED;
      return 1;
    end
    if (cur_len < Chars) begin
      cur_word[cur_len] = c;
      cur_len++;
    end else begin
      cur_over = 1'b1;
    end
    if (!e) return 0;
    if (f == koc_pkg::FUNC_KEY) begin
      if (kw_used >= Entries) begin
        t.status = koc_pkg::ST_FULL;
      end else if (cur_over) begin
        t.status = koc_pkg::ST_LONG;
      end else begin
        for (int i = 0; i < cur_len; i++) kw_text[kw_used][i] = cur_word[i];
        kw_len[kw_used] = 6'(cur_len);
        kw_hits[kw_used] = '0;
        t.index = 10'(kw_used);
        kw_used++;
      end
    end else if (cur_over) begin
      t.status = koc_pkg::ST_LONG;
    end else begin
      for (int k = 0; k < kw_used; k++) begin
        hit = (kw_len[k] == cur_len);
        for (int i = 0; i < cur_len; i++) if (kw_text[k][i] != cur_word[i]) hit = 0;
        if (hit) begin
          if (kw_hits[k] != '1) kw_hits[k]++;
          t = '{koc_pkg::ST_OK, 1'b1, 10'(k), kw_hits[k]};
          break;
        end
      end
    end
    cur_len = 0;
    cur_over = 0;
    return 1;
  endfunction

  task automatic send_word(input koc_pkg::func_e f, input logic [7:0] c, input logic e,
                           input logic [9:0] x, input bit typed = 0,
                           input tally_t want = '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0});
    tally_t t;
    while (!quiet_send && $urandom_range(99) < 16) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i <= f;
    char_code_i <= c;
    word_end_i <= e;
    entry_index_i <= x;
    do @(posedge clk_i); while (stall_o);
    items_sent++;
    if (count_step(f, c, e, x, t)) pending_tallies.push_back(typed ? want : t);
  endtask

  task automatic send_text_word(input koc_pkg::func_e f, input int unsigned len,
                                input bit wild);
    koc_pkg::func_e g;
    for (int i = 0; i < len; i++) begin
      g = f;
      if (i + 1 < len && $urandom_range(19) == 0) g = koc_pkg::func_e'($urandom_range(1));
      if ($urandom_range(29) == 0)
        send_word(koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'($urandom_range(kw_used + 3)));
      send_word(g, wild ? 8'($urandom) : pool[$urandom_range(3)], i + 1 == len,
                10'($urandom));
    end
  endtask

  task automatic drain;
    valid_i <= 1'b0;
    while (pending_tallies.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    tally_t w;
    cycle_no++;
    stall_i <= (cycle_no % 4000 > 1000) && ($urandom_range(99) < 16);
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= Watchdog) timed_out = 1;
    if (valid_o && !stall_i) begin
      if (pending_tallies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: status %0d index %0d count %0d",
                                       status_o, found_index_o, occurrences_o);
      end else begin
        w = pending_tallies.pop_front();
        if (status_o !== w.status || matched_o !== w.matched ||
            found_index_o !== w.index || occurrences_o !== w.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     w.status, w.matched, w.index, w.count,
                     status_o, matched_o, found_index_o, occurrences_o);
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    kw_used = 0;
    cur_len = 0;
    cur_over = 0;
    rows = '{
      '{koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'd0,    1,
        '{koc_pkg::ST_UNFILLED, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_NOP,  8'hFF, 1'b1, 10'd1023, 0, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_KEY,  8'h41, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_KEY,  8'hFF, 1'b0, 10'd0,    0, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_KEY,  8'h00, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd1, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h41, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b1, 10'd0, 32'd1}},
      '{koc_pkg::FUNC_TEXT, 8'hFF, 1'b0, 10'd0,    0, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'd1,    1, '{koc_pkg::ST_OK, 1'b0, 10'd1, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h00, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b1, 10'd1, 32'd1}},
      '{koc_pkg::FUNC_KEY,  8'h41, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd2, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h41, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b1, 10'd0, 32'd2}},
      '{koc_pkg::FUNC_KEY,  8'h42, 1'b0, 10'd0,    0, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h43, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h41, 1'b0, 10'd0,    0, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_KEY,  8'h5A, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd3, 32'd0}},
      '{koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'd1023, 1,
        '{koc_pkg::ST_UNFILLED, 1'b0, 10'd0, 32'd0}},
      '{koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'd3,    1, '{koc_pkg::ST_OK, 1'b0, 10'd3, 32'd0}},
      '{koc_pkg::FUNC_TEXT, 8'h42, 1'b1, 10'd0,    1, '{koc_pkg::ST_OK, 1'b0, 10'd0, 32'd0}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      begin
        foreach (rows[i])
          send_word(rows[i].func, rows[i].code, rows[i].last, rows[i].index,
                    rows[i].typed, rows[i].want);
        send_text_word(koc_pkg::FUNC_KEY, 32, 0);
        send_text_word(koc_pkg::FUNC_TEXT, 32, 0);
        send_text_word(koc_pkg::FUNC_KEY, 33, 0);
        send_text_word(koc_pkg::FUNC_TEXT, 40, 0);
        while (items_sent < 540) begin
          quiet_send = (items_sent > 250 && items_sent < 350);
          case ($urandom_range(19))
            0, 1:    send_word(koc_pkg::FUNC_READ, 8'($urandom), 1'($urandom), 10'($urandom));
            2:       send_word(koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'($urandom_range(kw_used)));
            3:       send_word(koc_pkg::FUNC_NOP, 8'($urandom), 1'($urandom), 10'($urandom));
            4:       send_text_word(koc_pkg::func_e'($urandom_range(1)),
                                    $urandom_range(32, 40), 0);
            5:       send_text_word(koc_pkg::func_e'($urandom_range(1)),
                                    $urandom_range(1, 32), 1);
            6, 7, 8: send_text_word(kw_used < 48 ? koc_pkg::FUNC_KEY : koc_pkg::FUNC_TEXT,
                                    $urandom_range(1, 4), 0);
            default: send_text_word(koc_pkg::FUNC_TEXT, $urandom_range(1, 4), 0);
          endcase
        end
        quiet_send = 0;
        drain();
        send_word(koc_pkg::FUNC_KEY, 8'h41, 1'b1, 10'd0);
        send_text_word(koc_pkg::FUNC_KEY, 34, 1);
        send_word(koc_pkg::FUNC_READ, 8'h00, 1'b0, 10'd1023);
        send_text_word(koc_pkg::FUNC_TEXT, 1, 0);
        send_text_word(koc_pkg::FUNC_TEXT, 2, 0);
        drain();
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("keyword_occurrence_counter regression: fail");
    end else if (mismatches == 0 && pending_tallies.size() == 0) begin
      $display("keyword_occurrence_counter regression: pass");
    end else begin
      $display("keyword_occurrence_counter regression: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/koc_pkg.sv
rtl/core/koc_ram.sv
rtl/core/keyword_occurrence_counter.sv
test/keyword_occurrence_counter_tb.sv
